// File: hw/rtl/lge_pkg.sv
// Shared types and constants of the life generation engine.
`default_nettype none
package lge_pkg;

	localparam int ROW_BITS   = 64;  // cells per row on the stream
	localparam int ROW_IDX_W  = 6;
	localparam int DIM_W      = 7;   // width_in_use / height_in_use
	localparam int ROUND_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int WALK_W     = 8;   // row walk counter, covers up to 127 rows plus two
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 88;

	localparam logic [ROUND_W-1:0] ROUND_RESET = 16'd100;
	localparam logic [3:0]         NBR_BIRTH   = 4'd3;
	localparam logic [3:0]         NBR_KEEP    = 4'd2;

	typedef enum logic [1:0] {
		KIND_WRITE   = 2'd0,
		KIND_ADVANCE = 2'd1,
		KIND_READ    = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_ROUNDS = 2'd2
	} cfg_idx_t;

endpackage
`default_nettype wire

// File: hw/rtl/lge_cell_lane.sv
// One cell of the B3/S23 rule: neighbor count and next state.
`default_nettype none
module lge_cell_lane (
	input  wire logic [7:0] nbr,
	input  wire logic       self_alive,
	output logic            next_alive
);
	import lge_pkg::*;

	logic [3:0] count;

	always_comb begin
		count = 4'd0;
		for (int k = 0; k < 8; k++) begin
			count = count + {3'd0, nbr[k]};
		end
	end

	assign next_alive = (count == NBR_BIRTH) || ((count == NBR_KEEP) && self_alive);

endmodule
`default_nettype wire

// File: hw/rtl/lge_row_engine.sv
// One lane per column over a three-row window, merged into the next row and a live flag.
`default_nettype none
module lge_row_engine #(
	parameter int COLS = 64
) (
	input  wire logic [COLS-1:0] up_row,
	input  wire logic [COLS-1:0] mid_row,
	input  wire logic [COLS-1:0] dn_row,
	input  wire logic [COLS-1:0] col_mask,
	input  wire logic            row_ok,
	output logic      [COLS-1:0] next_row,
	output logic                 next_live
);

	logic [COLS-1:0] lane_alive;

	for (genvar c = 0; c < COLS; c++) begin : g_lane
		logic [2:0] left_col;
		logic [2:0] right_col;

		if (c > 0) begin : g_left
			assign left_col = {up_row[c-1], mid_row[c-1], dn_row[c-1]};
		end else begin : g_left_edge
			assign left_col = 3'd0;
		end

		if (c < COLS - 1) begin : g_right
			assign right_col = {up_row[c+1], mid_row[c+1], dn_row[c+1]};
		end else begin : g_right_edge
			assign right_col = 3'd0;
		end

		lge_cell_lane u_lane (
			.nbr        ({left_col, right_col, up_row[c], dn_row[c]}),
			.self_alive (mid_row[c]),
			.next_alive (lane_alive[c])
		);
	end

	// rows past the height and columns past the width come out dead
	assign next_row  = row_ok ? (lane_alive & col_mask) : '0;
	assign next_live = |next_row;

endmodule
`default_nettype wire

// File: hw/rtl/life_generation_engine.sv
// Top level: grid memory, row walk sequencer, stream and configuration ports.
// Each item is dispatched; a write or read accesses its row, an advance with a
//   generation walks the grid, and kind 3, a no-op advance, or a row past the height
//   goes straight to the result. One item at a time: tready rises with result valid.
// After a width or height write the next item first rescans the grid.
// Reset clears every grid row in one pass, tready low meanwhile; config defaults apply.
`default_nettype none
module life_generation_engine #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// tdata: row_index[5:0], row_cells[69:6], zero[71:70]
	input  wire logic [lge_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// tuser: kind[1:0]
	input  wire logic [1:0]                          s_axis_tuser,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// tdata: row_cells_out[63:0], advanced[64], any_alive[65], rounds_left[81:66], zero[87:82]
	output logic      [lge_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [lge_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [lge_pkg::ROUND_W-1:0]         cfg_data
);
	import lge_pkg::*;

	localparam int GRID_ROWS = (MAX_ROWS < 127) ? MAX_ROWS : 127;
	localparam int RA        = $clog2(GRID_ROWS);
	localparam int CW        = $clog2(GRID_ROWS + 1);
	localparam int H_RESET   = (GRID_ROWS < 64) ? GRID_ROWS : 64;

	typedef enum logic [7:0] {
		ST_CLEAR    = 8'b0000_0001,
		ST_IDLE     = 8'b0000_0010,
		ST_SCAN     = 8'b0000_0100,
		ST_DISPATCH = 8'b0000_1000,
		ST_WRITE    = 8'b0001_0000,
		ST_READ     = 8'b0010_0000,
		ST_GEN      = 8'b0100_0000,
		ST_DONE     = 8'b1000_0000
	} state_t;

	state_t                   state_q;
	logic [WALK_W-1:0]        walk_q;
	logic [MAX_COLUMNS-1:0]   mask_q;
	logic [DIM_W-1:0]         height_q;
	logic [ROUND_W-1:0]       rounds_q;
	logic                     stale_q;
	logic [CW-1:0]            live_cnt_q;
	logic                     m_valid_q;
	logic                     rd_ok_q;
	logic                     mid_ok_q;

	kind_t                    kind_q;
	logic [ROW_IDX_W-1:0]     row_q;
	logic [MAX_COLUMNS-1:0]   cells_q;
	logic [MAX_COLUMNS-1:0]   res_row_q;
	logic                     adv_q;
	logic [MAX_COLUMNS-1:0]   up_q;
	logic [MAX_COLUMNS-1:0]   mid_q;
	logic [ROW_BITS-1:0]      out_row_q;
	logic                     out_adv_q;
	logic                     out_any_q;
	logic [ROUND_W-1:0]       out_rounds_q;

	logic [MAX_COLUMNS-1:0]   grid_mem [GRID_ROWS];
	logic [MAX_COLUMNS-1:0]   rd_q;
	logic                     mem_we;
	logic                     mem_re;
	logic [RA-1:0]            mem_wa;
	logic [RA-1:0]            mem_ra;
	logic [MAX_COLUMNS-1:0]   mem_wd;

	logic [RA-1:0]            walk_addr;
	logic                     walk_in_grid;
	logic                     walk_in_h;
	logic [WALK_W-1:0]        gen_idx;
	logic [RA-1:0]            gen_wa;
	logic [MAX_COLUMNS-1:0]   dn_row;
	logic [DIM_W-1:0]         row_ext;
	logic [RA-1:0]            row_addr;
	logic                     row_in_h;
	logic [MAX_COLUMNS-1:0]   new_row;
	logic                     new_live;
	logic                     old_live;
	logic [MAX_COLUMNS-1:0]   next_row;
	logic                     next_live;
	logic                     out_free;
	logic [DIM_W-1:0]         w_raw;
	logic [DIM_W-1:0]         w_eff;
	logic [DIM_W-1:0]         h_raw;
	logic [DIM_W-1:0]         h_eff;
	logic [MAX_COLUMNS-1:0]   mask_next;

	assign walk_addr    = walk_q[RA-1:0];
	assign walk_in_grid = walk_q < WALK_W'(GRID_ROWS);
	assign walk_in_h    = walk_q < {1'b0, height_q};
	assign gen_idx      = walk_q - WALK_W'(2);
	assign gen_wa       = gen_idx[RA-1:0];
	assign dn_row       = rd_ok_q ? (rd_q & mask_q) : '0;
	assign row_ext      = {1'b0, row_q};
	assign row_addr     = row_ext[RA-1:0];
	assign row_in_h     = row_ext < height_q;
	assign new_row      = cells_q & mask_q;
	assign new_live     = |new_row;
	assign old_live     = |(rd_q & mask_q);
	assign out_free     = !m_valid_q || m_axis_tready;

	// clamp of the configured width and height
	assign w_raw = cfg_data[DIM_W-1:0];
	assign h_raw = cfg_data[DIM_W-1:0];
	assign w_eff = (w_raw == '0) ? DIM_W'(1) :
		((w_raw > DIM_W'(MAX_COLUMNS)) ? DIM_W'(MAX_COLUMNS) : w_raw);
	assign h_eff = (h_raw == '0) ? DIM_W'(1) :
		((h_raw > DIM_W'(GRID_ROWS)) ? DIM_W'(GRID_ROWS) : h_raw);

	always_comb begin
		for (int j = 0; j < MAX_COLUMNS; j++) begin
			mask_next[j] = DIM_W'(j) < w_eff;
		end
	end

	lge_row_engine #(
		.COLS (MAX_COLUMNS)
	) u_row_engine (
		.up_row    (up_q),
		.mid_row   (mid_q),
		.dn_row    (dn_row),
		.col_mask  (mask_q),
		.row_ok    (mid_ok_q),
		.next_row  (next_row),
		.next_live (next_live)
	);

	// memory port steering
	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_wa = walk_addr;
		mem_ra = walk_addr;
		mem_wd = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_SCAN: begin
				mem_re = walk_in_grid;
			end
			ST_DISPATCH: begin
				mem_ra = row_addr;
				mem_re = row_in_h && ((kind_q == KIND_WRITE) || (kind_q == KIND_READ));
			end
			ST_WRITE: begin
				mem_we = 1'b1;
				mem_wa = row_addr;
				mem_wd = new_row;
			end
			ST_GEN: begin
				// row walk-2 is written in the same cycle as row walk is issued for reading
				mem_re = walk_in_grid;
				mem_we = walk_q >= WALK_W'(2);
				mem_wa = gen_wa;
				mem_wd = next_row;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			grid_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= grid_mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			walk_q     <= '0;
			mask_q     <= '1;
			height_q   <= DIM_W'(H_RESET);
			rounds_q   <= ROUND_RESET;
			stale_q    <= 1'b0;
			live_cnt_q <= '0;
			m_valid_q  <= 1'b0;
			rd_ok_q    <= 1'b0;
			mid_ok_q   <= 1'b0;
		end else begin
			if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					walk_q <= walk_q + WALK_W'(1);
					if (walk_q == WALK_W'(GRID_ROWS - 1)) begin
						walk_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						walk_q  <= '0;
						rd_ok_q <= 1'b0;
						if (stale_q) begin
							live_cnt_q <= '0;
							state_q    <= ST_SCAN;
						end else begin
							state_q <= ST_DISPATCH;
						end
					end
				end
				ST_SCAN: begin
					walk_q  <= walk_q + WALK_W'(1);
					rd_ok_q <= walk_in_grid && walk_in_h;
					if ((walk_q != '0) && (|dn_row)) begin
						live_cnt_q <= live_cnt_q + CW'(1);
					end
					if (walk_q == WALK_W'(GRID_ROWS)) begin
						stale_q <= 1'b0;
						state_q <= ST_DISPATCH;
					end
				end
				ST_DISPATCH: begin
					walk_q   <= '0;
					rd_ok_q  <= 1'b0;
					mid_ok_q <= 1'b0;
					unique case (kind_q)
						KIND_WRITE: begin
							state_q <= row_in_h ? ST_WRITE : ST_DONE;
						end
						KIND_READ: begin
							state_q <= row_in_h ? ST_READ : ST_DONE;
						end
						KIND_ADVANCE: begin
							state_q <= ST_DONE;
							if (rounds_q != '0) begin
								rounds_q <= rounds_q - ROUND_W'(1);
								if (live_cnt_q != '0) begin
									live_cnt_q <= '0;
									state_q    <= ST_GEN;
								end
							end
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_WRITE: begin
					live_cnt_q <= live_cnt_q + CW'(new_live) - CW'(old_live);
					state_q    <= ST_DONE;
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_GEN: begin
					walk_q  <= walk_q + WALK_W'(1);
					rd_ok_q <= walk_in_grid && walk_in_h;
					if (walk_q != '0) begin
						mid_ok_q <= rd_ok_q;
					end
					if ((walk_q >= WALK_W'(2)) && next_live) begin
						live_cnt_q <= live_cnt_q + CW'(1);
					end
					if (walk_q == WALK_W'(GRID_ROWS + 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cfg_valid) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_WIDTH: begin
						mask_q  <= mask_next;
						stale_q <= 1'b1;
					end
					CFG_HEIGHT: begin
						height_q <= h_eff;
						stale_q  <= 1'b1;
					end
					CFG_ROUNDS: begin
						rounds_q <= cfg_data;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// payload path
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					kind_q  <= kind_t'(s_axis_tuser);
					row_q   <= s_axis_tdata[ROW_IDX_W-1:0];
					cells_q <= s_axis_tdata[ROW_IDX_W +: MAX_COLUMNS];
				end
			end
			ST_DISPATCH: begin
				res_row_q <= '0;
				adv_q     <= (kind_q == KIND_ADVANCE) && (rounds_q != '0) && (live_cnt_q != '0);
				up_q      <= '0;
				mid_q     <= '0;
			end
			ST_READ: begin
				res_row_q <= rd_q & mask_q;
			end
			ST_GEN: begin
				if (walk_q != '0) begin
					up_q  <= mid_q;
					mid_q <= dn_row;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_row_q    <= ROW_BITS'(res_row_q);
					out_adv_q    <= adv_q;
					out_any_q    <= live_cnt_q != '0;
					out_rounds_q <= rounds_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign s_axis_tready = state_q == ST_IDLE;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {6'd0, out_rounds_q, out_any_q, out_adv_q, out_row_q};
	assign cfg_ready     = 1'b1;

endmodule
`default_nettype wire
